>>> hdl/swps_pkg.sv
`default_nettype none
package swps_pkg;

   localparam int WINDOW_MAX = 1024;
   localparam int SAMPLE_W   = 28;
   localparam int LEN_W      = 11;
   localparam int SEEN_W     = $clog2(WINDOW_MAX + 1);
   localparam int CNT_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int LEN_EFF_W  = (SEEN_W > LEN_W) ? SEEN_W : LEN_W;

   typedef logic [SAMPLE_W-1:0]  sample_type;
   typedef logic [LEN_W-1:0]     len_type;
   typedef logic [SEEN_W-1:0]    seen_type;
   typedef logic [CNT_W-1:0]     cnt_type;
   typedef logic [LEN_EFF_W-1:0] len_eff_type;

   // shift_dn: every cell takes its lower neighbour, cell 0 takes the new item
   // when insert is set; shift_up: every cell takes its upper neighbour
   typedef struct packed {
      logic shift_dn;
      logic shift_up;
      logic insert;
   } chain_ctrl_type;

endpackage
`default_nettype wire

>>> hdl/swps_cell.sv
`default_nettype none
module swps_cell (
   input  wire logic                 clock,
   input  wire logic                 shift_dn,
   input  wire logic                 shift_up,
   input  wire swps_pkg::sample_type from_lower,
   input  wire swps_pkg::sample_type from_upper,
   output swps_pkg::sample_type      value
);
   import swps_pkg::*;

   sample_type sample_ff;
   sample_type sample_in;

   always_comb begin
      sample_in = sample_ff;
      if (shift_dn) begin
         sample_in = from_lower;
      end else if (shift_up) begin
         sample_in = from_upper;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
   end

   assign value = sample_ff;

endmodule
`default_nettype wire

>>> hdl/swps_chain.sv
`default_nettype none
module swps_chain (
   input  wire logic                     clock,
   input  wire swps_pkg::chain_ctrl_type ctrl,
   input  wire swps_pkg::sample_type     new_sample,
   output swps_pkg::sample_type          head_next
);
   import swps_pkg::*;

   sample_type cell_value [WINDOW_MAX];
   sample_type head_lower;

   // ring: cell 0 holds the newest item, cell k the k-th older one
   assign head_lower = ctrl.insert ? new_sample : cell_value[WINDOW_MAX-1];

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      swps_cell u_cell (
         .clock      (clock),
         .shift_dn   (ctrl.shift_dn),
         .shift_up   (ctrl.shift_up),
         .from_lower ((i == 0) ? head_lower : cell_value[(i + WINDOW_MAX - 1) % WINDOW_MAX]),
         .from_upper (cell_value[(i + 1) % WINDOW_MAX]),
         .value      (cell_value[i])
      );
   end

   // value that moves into cell 0 on an upward shift
   assign head_next = cell_value[1 % WINDOW_MAX];

endmodule
`default_nettype wire

>>> hdl/sliding_window_peak_spread_top.sv
`default_nettype none
// sliding window peak spread
// req_ channel: one sample item per handshake, req_last closes the sequence.
// rsp_ channel: one spread item per sequence, given after its last sample;
// it is the largest (max - min) over every full window of window_len samples.
// csr_ channel: writes window_len; 0 acts as 1, values above 1024 act as 1024.
// Only write it while the block is idle; csr_ready is always high.
// Samples sit in a ring of 1024 cells. An item is shifted in, then, when a
// full window is present, the ring turns up by window_len-1 steps while the
// min and max are gathered from the cell next to the head, and turns back by
// the same count. req_ready is high only between items, so a new item waits
// until the last one is through. The result is registered; if the receiver
// stalls, the block finishes the next item but holds a new result until the
// old one is taken. Reset clears the sequence state and sets window_len to 1;
// the ring itself is not cleared and needs no clearing pass.
module sliding_window_peak_spread_top (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire swps_pkg::sample_type req_sample,
   input  wire logic                 req_last,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output swps_pkg::sample_type      rsp_spread,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire swps_pkg::len_type    csr_window_len
);
   import swps_pkg::*;

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_SCAN    = 2'd1;
   localparam logic [1:0] ST_RESTORE = 2'd2;
   localparam logic [1:0] ST_DONE    = 2'd3;

   logic [1:0]     state_ff, state_in;
   len_type        window_len_ff, window_len_in;
   seen_type       seen_ff, seen_in;
   sample_type     best_ff, best_in;
   sample_type     hi_ff, hi_in;
   sample_type     lo_ff, lo_in;
   cnt_type        cnt_ff, cnt_in;
   cnt_type        lenm1_ff, lenm1_in;
   logic           last_ff, last_in;
   logic           rsp_valid_ff, rsp_valid_in;
   sample_type     rsp_spread_ff, rsp_spread_in;

   chain_ctrl_type ctrl;
   sample_type     head_next;
   len_eff_type    len_eff;
   seen_type       seen_next;
   sample_type     diff;
   sample_type     best_upd;
   logic           accept;
   logic           out_free;

   swps_chain u_chain (
      .clock      (clock),
      .ctrl       (ctrl),
      .new_sample (req_sample),
      .head_next  (head_next)
   );

   assign csr_ready  = 1'b1;
   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_spread = rsp_spread_ff;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      len_eff = len_eff_type'(window_len_ff);
      if (window_len_ff == '0) begin
         len_eff = len_eff_type'(1);
      end else if (len_eff > len_eff_type'(WINDOW_MAX)) begin
         len_eff = len_eff_type'(WINDOW_MAX);
      end
   end

   assign seen_next = (seen_ff == seen_type'(WINDOW_MAX)) ? seen_ff : seen_ff + 1'b1;
   assign diff      = hi_ff - lo_ff;
   assign best_upd  = (diff > best_ff) ? diff : best_ff;

   always_comb begin
      state_in      = state_ff;
      window_len_in = window_len_ff;
      seen_in       = seen_ff;
      best_in       = best_ff;
      hi_in         = hi_ff;
      lo_in         = lo_ff;
      cnt_in        = cnt_ff;
      lenm1_in      = lenm1_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_spread_in = rsp_spread_ff;
      ctrl          = '0;

      if (csr_valid && csr_ready) begin
         window_len_in = csr_window_len;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ctrl.shift_dn = 1'b1;
               ctrl.insert   = 1'b1;
               seen_in       = seen_next;
               hi_in         = req_sample;
               lo_in         = req_sample;
               last_in       = req_last;
               lenm1_in      = cnt_type'(len_eff - 1'b1);
               cnt_in        = cnt_type'(1);
               if ((len_eff > len_eff_type'(1)) && (len_eff_type'(seen_next) >= len_eff)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            ctrl.shift_up = 1'b1;
            if (head_next > hi_ff) begin
               hi_in = head_next;
            end
            if (head_next < lo_ff) begin
               lo_in = head_next;
            end
            if (cnt_ff == lenm1_ff) begin
               cnt_in   = cnt_type'(1);
               state_in = ST_RESTORE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_RESTORE: begin
            ctrl.shift_dn = 1'b1;
            if (cnt_ff == lenm1_ff) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!last_ff) begin
               best_in  = best_upd;
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_spread_in = best_upd;
               best_in       = '0;
               seen_in       = '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         window_len_ff <= len_type'(1);
         seen_ff       <= '0;
         best_ff       <= '0;
         cnt_ff        <= '0;
         lenm1_ff      <= '0;
         last_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         window_len_ff <= window_len_in;
         seen_ff       <= seen_in;
         best_ff       <= best_in;
         cnt_ff        <= cnt_in;
         lenm1_ff      <= lenm1_in;
         last_ff       <= last_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff         <= hi_in;
      lo_ff         <= lo_in;
      rsp_spread_ff <= rsp_spread_in;
   end

   a_item_blocks_next: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("item accepted while previous item still in progress");

   a_seen_saturates: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= seen_type'(WINDOW_MAX))
      else $error("sample count beyond ring depth");

   a_scan_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_RESTORE) |-> (cnt_ff != '0) && (cnt_ff <= lenm1_ff))
      else $error("ring step count out of window");

   a_min_below_max: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_RESTORE || state_ff == ST_DONE) |-> lo_ff <= hi_ff)
      else $error("window minimum above maximum");

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE && $past(last_ff))
      else $error("result raised without a closing item");

endmodule
`default_nettype wire
